### src/bresenham_line_rasterizer_core_assert.svh
// Assertion macros for the line rasterizer core.
`ifndef BRESENHAM_LINE_RASTERIZER_CORE_ASSERT_SVH
`define BRESENHAM_LINE_RASTERIZER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define BLR_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");
`define BLR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define BLR_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define BLR_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

### src/blr_pkg.sv
// Types and constants shared by the line rasterizer modules.
package blr_pkg;

   localparam int COORD_BITS    = 12;
   localparam int DIFF_BITS     = COORD_BITS + 1;
   localparam int CUR_BITS      = COORD_BITS + 2;
   localparam int ERR_BITS      = COORD_BITS + 4;
   localparam int CNT_BITS      = COORD_BITS + 1;
   localparam int CFG_BITS      = 12;
   localparam int CMP_BITS      = (CUR_BITS > CFG_BITS) ? CUR_BITS : CFG_BITS;
   localparam int PROD_BITS     = 2 * CFG_BITS + 1;
   localparam int ADDR_BITS     = 22;
   localparam int COLOR_BITS    = 32;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam int REG_IDX_BIT   = 2;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_STEP = 1'b1;

   localparam logic REG_SCREEN_WIDTH  = 1'b0;
   localparam logic REG_SCREEN_HEIGHT = 1'b1;

   localparam logic [CFG_BITS-1:0] WIDTH_RESET  = CFG_BITS'(640);
   localparam logic [CFG_BITS-1:0] HEIGHT_RESET = CFG_BITS'(480);

   typedef struct packed {
      logic                         cmd;
      logic signed [COORD_BITS-1:0] start_x;
      logic signed [COORD_BITS-1:0] start_y;
      logic signed [COORD_BITS-1:0] end_x;
      logic signed [COORD_BITS-1:0] end_y;
      logic [COLOR_BITS-1:0]        line_color;
   } req_type;

   typedef struct packed {
      logic [ADDR_BITS-1:0]  pixel_address;
      logic [COLOR_BITS-1:0] pixel_color;
      logic                  write_enable;
      logic                  last_pixel;
   } rsp_type;

   typedef struct packed {
      logic [CFG_BITS-1:0] screen_width;
      logic [CFG_BITS-1:0] screen_height;
   } cfg_type;

   typedef struct packed {
      logic signed [CUR_BITS-1:0] origin_x;
      logic signed [CUR_BITS-1:0] origin_y;
      logic                       x_major;
      logic                       step_x_neg;
      logic                       step_y_neg;
      logic signed [ERR_BITS-1:0] error_term;
      logic signed [ERR_BITS-1:0] minor_inc;
      logic signed [ERR_BITS-1:0] both_inc;
      logic [CNT_BITS-1:0]        pixels_left;
      logic [COLOR_BITS-1:0]      color;
   } setup_type;

   typedef struct packed {
      logic signed [CUR_BITS-1:0] x;
      logic signed [CUR_BITS-1:0] y;
      logic [COLOR_BITS-1:0]      color;
      logic                       last;
   } pixel_type;

   typedef struct packed {
      logic      active;
      pixel_type pixel;
   } walk_type;

endpackage

### src/blr_csr.sv
// Configuration registers: screen width and height behind an APB-style port.
module blr_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [blr_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  logic [blr_pkg::CSR_DATA_BITS-1:0] pwdata,
   output logic [blr_pkg::CSR_DATA_BITS-1:0] prdata,
   output logic                              pready,
   output blr_pkg::cfg_type                  cfg
);

   logic [blr_pkg::CFG_BITS-1:0] width_ff;
   logic [blr_pkg::CFG_BITS-1:0] width_in;
   logic [blr_pkg::CFG_BITS-1:0] height_ff;
   logic [blr_pkg::CFG_BITS-1:0] height_in;
   logic                         wr_en;
   logic                         reg_sel;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_sel = paddr[blr_pkg::REG_IDX_BIT];

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (wr_en) begin
         unique case (reg_sel)
            blr_pkg::REG_SCREEN_WIDTH:  width_in  = pwdata[blr_pkg::CFG_BITS-1:0];
            blr_pkg::REG_SCREEN_HEIGHT: height_in = pwdata[blr_pkg::CFG_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         blr_pkg::REG_SCREEN_WIDTH:  prdata = blr_pkg::CSR_DATA_BITS'(width_ff);
         blr_pkg::REG_SCREEN_HEIGHT: prdata = blr_pkg::CSR_DATA_BITS'(height_ff);
         default:                    prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= blr_pkg::WIDTH_RESET;
         height_ff <= blr_pkg::HEIGHT_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   assign cfg.screen_width  = width_ff;
   assign cfg.screen_height = height_ff;

endmodule

### src/blr_setup.sv
// Line setup: spans, directions, major axis and error increments from two endpoints.
module blr_setup (
   input  blr_pkg::req_type   req,
   output blr_pkg::setup_type setup
);

   logic signed [blr_pkg::DIFF_BITS-1:0] du;
   logic signed [blr_pkg::DIFF_BITS-1:0] dv;
   logic signed [blr_pkg::DIFF_BITS-1:0] du_abs;
   logic signed [blr_pkg::DIFF_BITS-1:0] dv_abs;
   logic [blr_pkg::COORD_BITS-1:0]       span_x;
   logic [blr_pkg::COORD_BITS-1:0]       span_y;
   logic [blr_pkg::COORD_BITS-1:0]       major;
   logic [blr_pkg::COORD_BITS-1:0]       minor;
   logic                                 x_major;
   logic signed [blr_pkg::ERR_BITS-1:0]  major_w;
   logic signed [blr_pkg::ERR_BITS-1:0]  minor2_w;

   always_comb begin
      du       = blr_pkg::DIFF_BITS'(req.end_x) - blr_pkg::DIFF_BITS'(req.start_x);
      dv       = blr_pkg::DIFF_BITS'(req.end_y) - blr_pkg::DIFF_BITS'(req.start_y);
      du_abs   = du[blr_pkg::DIFF_BITS-1] ? -du : du;
      dv_abs   = dv[blr_pkg::DIFF_BITS-1] ? -dv : dv;
      span_x   = du_abs[blr_pkg::COORD_BITS-1:0];
      span_y   = dv_abs[blr_pkg::COORD_BITS-1:0];
      x_major  = span_x > span_y;
      major    = x_major ? span_x : span_y;
      minor    = x_major ? span_y : span_x;
      major_w  = signed'(blr_pkg::ERR_BITS'(major));
      minor2_w = signed'(blr_pkg::ERR_BITS'(minor) << 1);

      setup.origin_x    = blr_pkg::CUR_BITS'(req.start_x);
      setup.origin_y    = blr_pkg::CUR_BITS'(req.start_y);
      setup.x_major     = x_major;
      setup.step_x_neg  = du[blr_pkg::DIFF_BITS-1];
      setup.step_y_neg  = dv[blr_pkg::DIFF_BITS-1];
      setup.error_term  = major_w - minor2_w;
      setup.minor_inc   = -minor2_w;
      setup.both_inc    = (major_w <<< 1) - minor2_w;
      setup.pixels_left = blr_pkg::CNT_BITS'(major) + blr_pkg::CNT_BITS'(1);
      setup.color       = req.line_color;
   end

endmodule

### src/blr_walker.sv
// Line state: current pixel, error term and pixel count, advanced one pixel per step.
module blr_walker (
   input  logic               clock,
   input  logic               reset,
   input  logic               load_fire,
   input  logic               step_fire,
   input  blr_pkg::setup_type setup,
   output blr_pkg::walk_type  walk
);

   logic                                active_ff;
   logic                                active_in;
   logic signed [blr_pkg::CUR_BITS-1:0] x_ff;
   logic signed [blr_pkg::CUR_BITS-1:0] x_in;
   logic signed [blr_pkg::CUR_BITS-1:0] y_ff;
   logic signed [blr_pkg::CUR_BITS-1:0] y_in;
   logic                                x_major_ff;
   logic                                x_major_in;
   logic                                step_x_neg_ff;
   logic                                step_x_neg_in;
   logic                                step_y_neg_ff;
   logic                                step_y_neg_in;
   logic signed [blr_pkg::ERR_BITS-1:0] err_ff;
   logic signed [blr_pkg::ERR_BITS-1:0] err_in;
   logic signed [blr_pkg::ERR_BITS-1:0] minor_inc_ff;
   logic signed [blr_pkg::ERR_BITS-1:0] minor_inc_in;
   logic signed [blr_pkg::ERR_BITS-1:0] both_inc_ff;
   logic signed [blr_pkg::ERR_BITS-1:0] both_inc_in;
   logic [blr_pkg::CNT_BITS-1:0]        left_ff;
   logic [blr_pkg::CNT_BITS-1:0]        left_in;
   logic [blr_pkg::COLOR_BITS-1:0]      color_ff;
   logic [blr_pkg::COLOR_BITS-1:0]      color_in;
   logic signed [blr_pkg::CUR_BITS-1:0] step_x;
   logic signed [blr_pkg::CUR_BITS-1:0] step_y;
   logic                                last;
   logic                                diag;

   assign step_x = step_x_neg_ff ? '1 : blr_pkg::CUR_BITS'(1);
   assign step_y = step_y_neg_ff ? '1 : blr_pkg::CUR_BITS'(1);
   assign last   = left_ff <= blr_pkg::CNT_BITS'(1);
   assign diag   = err_ff[blr_pkg::ERR_BITS-1];

   always_comb begin
      active_in     = active_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      x_major_in    = x_major_ff;
      step_x_neg_in = step_x_neg_ff;
      step_y_neg_in = step_y_neg_ff;
      err_in        = err_ff;
      minor_inc_in  = minor_inc_ff;
      both_inc_in   = both_inc_ff;
      left_in       = left_ff;
      color_in      = color_ff;
      if (load_fire) begin
         active_in     = 1'b1;
         x_in          = setup.origin_x;
         y_in          = setup.origin_y;
         x_major_in    = setup.x_major;
         step_x_neg_in = setup.step_x_neg;
         step_y_neg_in = setup.step_y_neg;
         err_in        = setup.error_term;
         minor_inc_in  = setup.minor_inc;
         both_inc_in   = setup.both_inc;
         left_in       = setup.pixels_left;
         color_in      = setup.color;
      end else if (step_fire && active_ff) begin
         if (x_major_ff || diag) begin
            x_in = x_ff + step_x;
         end
         if (!x_major_ff || diag) begin
            y_in = y_ff + step_y;
         end
         err_in = err_ff + (diag ? both_inc_ff : minor_inc_ff);
         if (last) begin
            left_in   = '0;
            active_in = 1'b0;
         end else begin
            left_in = left_ff - blr_pkg::CNT_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff          <= x_in;
      y_ff          <= y_in;
      x_major_ff    <= x_major_in;
      step_x_neg_ff <= step_x_neg_in;
      step_y_neg_ff <= step_y_neg_in;
      err_ff        <= err_in;
      minor_inc_ff  <= minor_inc_in;
      both_inc_ff   <= both_inc_in;
      left_ff       <= left_in;
      color_ff      <= color_in;
   end

   assign walk.active      = active_ff;
   assign walk.pixel.x     = x_ff;
   assign walk.pixel.y     = y_ff;
   assign walk.pixel.color = color_ff;
   assign walk.pixel.last  = last;

endmodule

### src/blr_pixel_out.sv
// Clip test, linear address and the result register of the pixel channel.
module blr_pixel_out (
   input  logic               clock,
   input  logic               reset,
   input  logic               pix_fire,
   input  blr_pkg::pixel_type pixel,
   input  blr_pkg::cfg_type   cfg,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   output blr_pkg::rsp_type   rsp_data
);

   logic                            valid_ff;
   logic                            valid_in;
   blr_pkg::rsp_type                data_ff;
   blr_pkg::rsp_type                data_in;
   logic [blr_pkg::CMP_BITS-1:0]    x_cmp;
   logic [blr_pkg::CMP_BITS-1:0]    y_cmp;
   logic [blr_pkg::CFG_BITS-1:0]    x_col;
   logic [blr_pkg::CFG_BITS-1:0]    y_row;
   logic [2*blr_pkg::CFG_BITS-1:0]  row_base;
   logic [blr_pkg::PROD_BITS-1:0]   addr_wide;
   logic                            on_screen;

   always_comb begin
      x_cmp     = blr_pkg::CMP_BITS'($unsigned(pixel.x));
      y_cmp     = blr_pkg::CMP_BITS'($unsigned(pixel.y));
      on_screen = !pixel.x[blr_pkg::CUR_BITS-1] && !pixel.y[blr_pkg::CUR_BITS-1] &&
                  (x_cmp < blr_pkg::CMP_BITS'(cfg.screen_width)) &&
                  (y_cmp < blr_pkg::CMP_BITS'(cfg.screen_height));
      x_col     = blr_pkg::CFG_BITS'($unsigned(pixel.x));
      y_row     = blr_pkg::CFG_BITS'($unsigned(pixel.y));
      row_base  = y_row * cfg.screen_width;
      addr_wide = blr_pkg::PROD_BITS'(row_base) + blr_pkg::PROD_BITS'(x_col);

      data_in.pixel_address = on_screen ? addr_wide[blr_pkg::ADDR_BITS-1:0] : '0;
      data_in.pixel_color   = pixel.color;
      data_in.write_enable  = on_screen;
      data_in.last_pixel    = pixel.last;
   end

   always_comb begin
      priority if (pix_fire) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pix_fire) begin
         data_ff <= data_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

### src/bresenham_line_rasterizer_core.sv
// Bresenham line rasterizer top level: load and step channel, pixel channel, registers.
//
// Usage: a transfer on req_ with cmd = load latches two endpoints and a color and
// starts a new line (replacing any line in progress); it gives no pixel. Each later
// transfer with cmd = step gives one pixel on rsp_: the linear address y * width + x,
// the color, write_enable (clear and address zero when the pixel is off screen) and
// last_pixel on the final pixel. A step with no line in progress gives nothing.
// A step's pixel appears on rsp_valid in the cycle after its transfer.
// Throughput: one item per cycle while rsp_ready keeps the output free; the line state and
// the result register both update in the same cycle, with the address multiply between them.
// Stall: while a pixel waits with rsp_ready low, req_ready drops and nothing is lost;
// req_ready returns in the cycle the pixel is taken.
// Reset: no line in progress, result register empty, screen 640 x 480.
// Registers (psel/penable/pwrite, pready always high): 0x0 screen_width,
// 0x4 screen_height, 12 bits each; write them only while the block is idle.
module bresenham_line_rasterizer_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  blr_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output blr_pkg::rsp_type                  rsp_data,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [blr_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  logic [blr_pkg::CSR_DATA_BITS-1:0] pwdata,
   output logic [blr_pkg::CSR_DATA_BITS-1:0] prdata,
   output logic                              pready
);

`include "bresenham_line_rasterizer_core_assert.svh"

   blr_pkg::cfg_type   cfg;
   blr_pkg::setup_type setup;
   blr_pkg::walk_type  walk;
   logic               req_fire;
   logic               load_fire;
   logic               step_fire;
   logic               pix_fire;

   assign req_ready = !rsp_valid || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign load_fire = req_fire && (req_data.cmd == blr_pkg::CMD_LOAD);
   assign step_fire = req_fire && (req_data.cmd == blr_pkg::CMD_STEP);
   assign pix_fire  = step_fire && walk.active;

   blr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   blr_setup u_setup (
      .req   (req_data),
      .setup (setup)
   );

   blr_walker u_walker (
      .clock     (clock),
      .reset     (reset),
      .load_fire (load_fire),
      .step_fire (step_fire),
      .setup     (setup),
      .walk      (walk)
   );

   blr_pixel_out u_pixel_out (
      .clock     (clock),
      .reset     (reset),
      .pix_fire  (pix_fire),
      .pixel     (walk.pixel),
      .cfg       (cfg),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   `BLR_ASSERT_SAME(a_stall_blocks_req, clock, reset, rsp_valid && !rsp_ready, !req_ready)
   `BLR_ASSERT_NEXT(a_load_starts_line, clock, reset, load_fire, walk.active)
   `BLR_ASSERT_NEXT(a_idle_step_silent, clock, reset,
      step_fire && !walk.active && !rsp_valid, !rsp_valid)
   `BLR_ASSERT_NEXT(a_last_ends_line, clock, reset, pix_fire && walk.pixel.last,
      !walk.active && rsp_valid && rsp_data.last_pixel)

endmodule

### tb/sv/bresenham_line_rasterizer_core_checker.sv
// Pixel predictor and scoreboard for the line rasterizer core.
`timescale 1ns / 100ps
module bresenham_line_rasterizer_core_checker (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   input  logic                                      req_ready,
   input  blr_pkg::req_type                          req_data,
   input  logic                                      rsp_valid,
   input  logic                                      rsp_ready,
   input  blr_pkg::rsp_type                          rsp_data,
   input  logic                                      psel,
   input  logic                                      penable,
   input  logic                                      pwrite,
   input  logic                                      pready,
   input  logic [blr_pkg::CSR_ADDR_BITS-1:0]         paddr,
   input  logic [blr_pkg::CSR_DATA_BITS-1:0]         pwdata,
   output int                                        pixels_pending,
   output int                                        mismatch_count
);

   logic [blr_pkg::CFG_BITS-1:0]          width_reg;
   logic [blr_pkg::CFG_BITS-1:0]          height_reg;
   logic                                  line_on;
   logic signed [blr_pkg::COORD_BITS-1:0] org_x;
   logic signed [blr_pkg::COORD_BITS-1:0] org_y;
   logic signed [blr_pkg::DIFF_BITS-1:0]  off_x;
   logic signed [blr_pkg::DIFF_BITS-1:0]  off_y;
   logic                                  x_is_major;
   logic                                  x_back;
   logic                                  y_back;
   logic signed [blr_pkg::ERR_BITS-1:0]   err;
   logic signed [blr_pkg::ERR_BITS-1:0]   err_minor_inc;
   logic signed [blr_pkg::ERR_BITS-1:0]   err_both_inc;
   logic [blr_pkg::CNT_BITS-1:0]          remaining;
   logic [blr_pkg::COLOR_BITS-1:0]        color_hold;
   blr_pkg::rsp_type                      pixels_due[$];

   function automatic void start_line(input blr_pkg::req_type r);
      int du, dv, major, minor;
      du = int'($signed(r.end_x)) - int'($signed(r.start_x));
      dv = int'($signed(r.end_y)) - int'($signed(r.start_y));
      x_back = (du < 0);
      y_back = (dv < 0);
      if (du < 0) du = -du;
      if (dv < 0) dv = -dv;
      x_is_major = (du > dv);
      major = x_is_major ? du : dv;
      minor = x_is_major ? dv : du;
      org_x = r.start_x;
      org_y = r.start_y;
      off_x = '0;
      off_y = '0;
      err = blr_pkg::ERR_BITS'(major - 2 * minor);
      err_minor_inc = blr_pkg::ERR_BITS'(-2 * minor);
      err_both_inc = blr_pkg::ERR_BITS'(2 * major - 2 * minor);
      remaining = blr_pkg::CNT_BITS'(major + 1);
      color_hold = r.line_color;
      line_on = 1'b1;
   endfunction

   function automatic void trace_pixel();
      int               px, py, sx, sy;
      logic             on, last;
      logic [31:0]      lin;
      blr_pkg::rsp_type pix;
      if (!line_on) return;
      px = int'(org_x) + int'(off_x);
      py = int'(org_y) + int'(off_y);
      on = (px >= 0) && (py >= 0) && (px < int'(width_reg)) && (py < int'(height_reg));
      lin = 32'(py) * 32'(width_reg) + 32'(px);
      last = (remaining <= 1);
      pix.pixel_address = on ? lin[blr_pkg::ADDR_BITS-1:0] : '0;
      pix.pixel_color = color_hold;
      pix.write_enable = on;
      pix.last_pixel = last;
      pixels_due.push_back(pix);
      sx = x_back ? -1 : 1;
      sy = y_back ? -1 : 1;
      if (x_is_major) begin
         off_x = blr_pkg::DIFF_BITS'(int'(off_x) + sx);
         if (err < 0) begin
            off_y = blr_pkg::DIFF_BITS'(int'(off_y) + sy);
            err = blr_pkg::ERR_BITS'(int'(err) + int'(err_both_inc));
         end else begin
            err = blr_pkg::ERR_BITS'(int'(err) + int'(err_minor_inc));
         end
      end else begin
         off_y = blr_pkg::DIFF_BITS'(int'(off_y) + sy);
         if (err < 0) begin
            off_x = blr_pkg::DIFF_BITS'(int'(off_x) + sx);
            err = blr_pkg::ERR_BITS'(int'(err) + int'(err_both_inc));
         end else begin
            err = blr_pkg::ERR_BITS'(int'(err) + int'(err_minor_inc));
         end
      end
      if (last) begin
         remaining = '0;
         line_on = 1'b0;
      end else begin
         remaining = remaining - 1'b1;
      end
   endfunction

   function automatic void match_pixel(input blr_pkg::rsp_type got);
      blr_pkg::rsp_type want;
      if (pixels_due.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("unexpected pixel: addr=%h color=%h we=%b last=%b",
                     got.pixel_address, got.pixel_color, got.write_enable, got.last_pixel);
         return;
      end
      want = pixels_due.pop_front();
      if (got.pixel_address !== want.pixel_address || got.pixel_color !== want.pixel_color ||
          got.write_enable !== want.write_enable || got.last_pixel !== want.last_pixel) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display({"pixel mismatch: expected addr=%h color=%h we=%b last=%b, ",
                      "got addr=%h color=%h we=%b last=%b"},
                     want.pixel_address, want.pixel_color, want.write_enable, want.last_pixel,
                     got.pixel_address, got.pixel_color, got.write_enable, got.last_pixel);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         width_reg = blr_pkg::WIDTH_RESET;
         height_reg = blr_pkg::HEIGHT_RESET;
         line_on = 1'b0;
         org_x = '0;
         org_y = '0;
         off_x = '0;
         off_y = '0;
         x_is_major = 1'b0;
         x_back = 1'b0;
         y_back = 1'b0;
         err = '0;
         err_minor_inc = '0;
         err_both_inc = '0;
         remaining = '0;
         color_hold = '0;
         pixels_due.delete();
         mismatch_count = 0;
      end else begin
         if (rsp_valid && rsp_ready)
            match_pixel(rsp_data);
         if (req_valid && req_ready) begin
            if (req_data.cmd == blr_pkg::CMD_LOAD)
               start_line(req_data);
            else
               trace_pixel();
         end
         if (psel && penable && pwrite && pready) begin
            if (paddr[blr_pkg::REG_IDX_BIT] == blr_pkg::REG_SCREEN_WIDTH)
               width_reg = pwdata[blr_pkg::CFG_BITS-1:0];
            else
               height_reg = pwdata[blr_pkg::CFG_BITS-1:0];
         end
      end
      pixels_pending = pixels_due.size();
   end

endmodule

### tb/sv/bresenham_line_rasterizer_core_test.sv
// Stimulus, handshake pacing and verdict for the line rasterizer core.
`timescale 1ns / 100ps
module bresenham_line_rasterizer_core_test;

   localparam int PHASES          = 8;
   localparam int PHASE_ITEMS     = 200;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int WATCHDOG_LIMIT  = 4000;
   localparam int DRAIN_CYCLES    = 20;

   int phase_width [PHASES]  = '{640, 1, 4095, 2048, 320, 2047, 100, 0};
   int phase_height [PHASES] = '{480, 1, 4095, 480, 0, 1, 60, 0};
   int phase_idle [PHASES]   = '{0, 79, 0, 31, 0, 79, 0, 31};
   int phase_stall [PHASES]  = '{0, 0, 79, 31, 0, 0, 79, 31};

   logic                              clock;
   logic                              reset = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_ready;
   blr_pkg::req_type                  req_data = '0;
   logic                              rsp_valid;
   logic                              rsp_ready = 1'b0;
   blr_pkg::rsp_type                  rsp_data;
   logic                              psel = 1'b0;
   logic                              penable = 1'b0;
   logic                              pwrite = 1'b0;
   logic [blr_pkg::CSR_ADDR_BITS-1:0] paddr = '0;
   logic [blr_pkg::CSR_DATA_BITS-1:0] pwdata = '0;
   logic [blr_pkg::CSR_DATA_BITS-1:0] prdata;
   logic                              pready;

   int pixels_pending;
   int mismatch_count;
   int req_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_requests = 0;
   int hold_served = 0;
   int hold_left = 0;
   int idle_cycles = 0;
   int scr_w = 640;
   int scr_h = 480;

   bresenham_line_rasterizer_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   bresenham_line_rasterizer_core_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .pready         (pready),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .pixels_pending (pixels_pending),
      .mismatch_count (mismatch_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      if (hold_served != hold_requests) begin
         hold_served = hold_requests;
         hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || psel) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic blr_pkg::req_type line_request(
      input int x0, input int y0, input int x1, input int y1,
      input logic [blr_pkg::COLOR_BITS-1:0] c);
      blr_pkg::req_type r;
      r.cmd = blr_pkg::CMD_LOAD;
      r.start_x = blr_pkg::COORD_BITS'(x0);
      r.start_y = blr_pkg::COORD_BITS'(y0);
      r.end_x = blr_pkg::COORD_BITS'(x1);
      r.end_y = blr_pkg::COORD_BITS'(y1);
      r.line_color = c;
      return r;
   endfunction

   function automatic blr_pkg::req_type step_request();
      blr_pkg::req_type r;
      r = line_request($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
      r.cmd = blr_pkg::CMD_STEP;
      return r;
   endfunction

   function automatic int pick_start(input int d, input int lim);
      int c, lo, hi;
      case ($urandom_range(3))
         0: c = int'($urandom_range(4095)) - 2048;
         1: c = int'($urandom_range(52)) - 12;
         2: c = lim + int'($urandom_range(16)) - 8;
         default: c = $urandom_range(1) ? 2047 - int'($urandom_range(7))
                                        : int'($urandom_range(7)) - 2048;
      endcase
      lo = (d < 0) ? -2048 - d : -2048;
      hi = (d > 0) ? 2047 - d : 2047;
      if (c < lo) c = lo;
      if (c > hi) c = hi;
      return c;
   endfunction

   task automatic offer(input blr_pkg::req_type item);
      if (req_idle_pct != 0 && $urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < req_idle_pct);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic step_n(input int n);
      for (int i = 0; i < n; i++)
         offer(step_request());
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (pixels_pending != 0);
      repeat (3) @(posedge clock);
   endtask

   task automatic csr_write(input logic idx, input int value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= blr_pkg::CSR_DATA_BITS'(value);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_lines(input int quota);
      int counted, x0, y0, x1, y1, dx, dy, span, len, steps;
      counted = 0;
      while (counted < quota) begin
         if ($urandom_range(99) < 4) begin
            x0 = int'($urandom_range(4095)) - 2048;
            y0 = int'($urandom_range(4095)) - 2048;
            x1 = int'($urandom_range(4095)) - 2048;
            y1 = int'($urandom_range(4095)) - 2048;
         end else begin
            span = ($urandom_range(99) < 8) ? 200 : 8;
            dx = int'($urandom_range(2 * span)) - span;
            dy = int'($urandom_range(2 * span)) - span;
            if ($urandom_range(9) == 0)
               dy = $urandom_range(1) ? dx : -dx;
            x0 = pick_start(dx, scr_w);
            y0 = pick_start(dy, scr_h);
            x1 = x0 + dx;
            y1 = y0 + dy;
         end
         dx = (x1 > x0) ? x1 - x0 : x0 - x1;
         dy = (y1 > y0) ? y1 - y0 : y0 - y1;
         len = ((dx > dy) ? dx : dy) + 1;
         if (len > 400)
            steps = $urandom_range(12);
         else if ($urandom_range(9) == 0)
            steps = $urandom_range(len - 1);
         else
            steps = len + int'($urandom_range(2));
         offer(line_request(x0, y0, x1, y1, $urandom()));
         counted++;
         for (int i = 0; i < steps; i++) begin
            offer(step_request());
            if (i < len) counted++;
         end
      end
   endtask

   initial begin
      int w, h;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      step_n(1);
      offer(line_request(5, 5, 5, 5, 32'h0000_0000));
      step_n(2);
      offer(line_request(0, 0, 3, 1, 32'hFFFF_FFFF));
      step_n(4);
      offer(line_request(2, 2, -1, -1, 32'hA5A5_A5A5));
      step_n(4);
      offer(line_request(-2048, -2048, 2047, 2047, 32'h1234_5678));
      step_n(2);
      offer(line_request(2047, -2048, -2048, 2047, 32'h8000_0001));
      step_n(2);
      offer(line_request(639, 479, 641, 478, 32'h5A5A_5A5A));
      step_n(3);

      for (int p = 0; p < PHASES; p++) begin
         drain();
         w = (p == PHASES - 1) ? int'($urandom_range(4095)) : phase_width[p];
         h = (p == PHASES - 1) ? int'($urandom_range(4095)) : phase_height[p];
         csr_write(blr_pkg::REG_SCREEN_WIDTH, w);
         csr_write(blr_pkg::REG_SCREEN_HEIGHT, h);
         scr_w = w % 4096;
         scr_h = h % 4096;
         req_idle_pct = phase_idle[p];
         rsp_stall_pct <= phase_stall[p];
         if (p == 0)
            hold_requests <= hold_requests + 1;
         random_lines(PHASE_ITEMS);
      end

      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pixels_pending == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

### files.f
+incdir+src
src/blr_pkg.sv
src/blr_csr.sv
src/blr_setup.sv
src/blr_walker.sv
src/blr_pixel_out.sv
src/bresenham_line_rasterizer_core.sv
tb/sv/bresenham_line_rasterizer_core_checker.sv
tb/sv/bresenham_line_rasterizer_core_test.sv
